/* sv/kabf_pkg.sv */
package kabf_pkg;

  localparam int unsigned AngleW = 25;
  localparam int unsigned RateW  = 28;
  localparam int unsigned DtW    = 16;
  localparam int unsigned NoiseW = 24;
  localparam int unsigned StateW = 32;
  localparam int unsigned BiasW  = 28;

  localparam logic [23:0] QaReset = 24'd16777;
  localparam logic [23:0] QbReset = 24'd50332;
  localparam logic [23:0] RReset  = 24'd503316;
  localparam logic signed [31:0] BiasLimit = 32'sd131072000;

  // register indexes
  localparam logic [1:0] RegQa = 2'd0;
  localparam logic [1:0] RegQb = 2'd1;
  localparam logic [1:0] RegR  = 2'd2;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } kabf_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } kabf_div_rsp_t;

  // saturate a wide value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* sv/kalman_angle_bias_filter_core.sv */
// Channel   Direction  Handshake        Payload
// input     in         in_valid/stall   measured_angle, measured_rate, time_step
// output    out        out_valid/stall  filtered_angle, bias_estimate
// config    in         cfg_we           cfg_index, cfg_data
//
// A request is taken only when idle; its result is registered after its
// sequencing steps, ten multiplies on one shared 34x34 multiplier and two
// serial divides. With a zero divisor both divides are skipped. The next
// request can be taken in the cycle after the result is registered.
// Synchronous reset zeroes state and loads the default noise registers.
// A finished result sits in the output register; the next request is taken
// while it waits, and completion stalls only while that register is full and stalled.
module kalman_angle_bias_filter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [24:0]             measured_angle,
  input  logic signed [27:0]             measured_rate,
  input  logic [15:0]                    time_step,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             filtered_angle,
  output logic signed [27:0]             bias_estimate,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [23:0]                    cfg_data
);
  import kabf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_M_ANG, S_M_P11, S_W_P11, S_M_T, S_M_QB, S_W_PRED,
    S_DIV0, S_WD0, S_DIV1, S_WD1, S_M_KY0, S_M_KY1, S_M_K0P00, S_M_K0P01,
    S_M_K1P00, S_M_K1P01, S_DONE
  } state_t;

  state_t state;
  logic [23:0] qa, qb, rn;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [24:0] ma;
  logic signed [27:0] mr;
  logic [15:0] dt;
  logic signed [31:0] k0, k1, y, dtp11, p00t, p01t;
  logic signed [33:0] t;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  kabf_div_req_t dreq;
  kabf_div_rsp_t drsp;
  logic signed [67:0] sh16, sh24;
  logic signed [67:0] tsum;
  logic signed [63:0] s_full;

  kabf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // shared multiplier
  assign prod = mul_a * mul_b;
  assign sh16 = 68'(prod >>> 16);
  assign sh24 = 68'(prod >>> 24);
  // covariance term, up to about three times the 32-bit range
  assign tsum = 68'(dtp11) - 68'(p01) - 68'(p10) + 68'($signed({1'b0, qa}));
  assign s_full = 64'(p00) + 64'($signed({1'b0, rn}));

  // operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M_ANG: begin
        mul_a = 34'($signed({1'b0, dt}));
        mul_b = 34'(mr) - 34'(bias);
      end
      S_M_P11: begin
        mul_a = 34'($signed({1'b0, dt}));
        mul_b = 34'(p11);
      end
      S_M_T: begin
        mul_a = 34'($signed({1'b0, dt}));
        mul_b = t;
      end
      S_M_QB: begin
        mul_a = 34'($signed({1'b0, dt}));
        mul_b = 34'($signed({1'b0, qb}));
      end
      S_M_KY0:   begin mul_a = 34'(k0); mul_b = 34'(y);    end
      S_M_KY1:   begin mul_a = 34'(k1); mul_b = 34'(y);    end
      S_M_K0P00: begin mul_a = 34'(k0); mul_b = 34'(p00t); end
      S_M_K0P01: begin mul_a = 34'(k0); mul_b = 34'(p01t); end
      S_M_K1P00: begin mul_a = 34'(k1); mul_b = 34'(p00t); end
      S_M_K1P01: begin mul_a = 34'(k1); mul_b = 34'(p01t); end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qa        <= QaReset;
      qb        <= QbReset;
      rn        <= RReset;
      ang       <= '0;
      bias      <= '0;
      p00       <= '0;
      p01       <= '0;
      p10       <= '0;
      p11       <= '0;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      // divider launch, one pulse per divide
      dreq.start <= ((state == S_DIV0) && (s_full != 64'sd0)) || (state == S_DIV1);
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          RegQa:   qa <= cfg_data;
          RegQb:   qb <= cfg_data;
          RegR:    rn <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          ma    <= measured_angle;
          mr    <= measured_rate;
          dt    <= time_step;
          state <= S_M_ANG;
        end
        S_M_ANG: begin
          ang   <= sat32(68'(ang) + sh16);
          state <= S_M_P11;
        end
        S_M_P11: begin
          dtp11 <= sh16[31:0];
          state <= S_W_P11;
        end
        S_W_P11: begin
          t     <= tsum[33:0];
          state <= S_M_T;
        end
        S_M_T: begin
          p00   <= sat32(68'(p00) + sh16);
          p01   <= sat32(68'(p01) - 68'(dtp11));
          p10   <= sat32(68'(p10) - 68'(dtp11));
          state <= S_M_QB;
        end
        S_M_QB: begin
          p11   <= sat32(68'(p11) + sh16);
          state <= S_W_PRED;
        end
        S_W_PRED: begin
          y     <= sat32(68'(ma) - 68'(ang));
          p00t  <= p00;
          p01t  <= p01;
          state <= S_DIV0;
        end
        S_DIV0: begin
          if (s_full == 64'sd0) begin
            k0    <= '0;
            k1    <= '0;
            state <= S_M_KY0;
          end else begin
            dreq.num   <= 64'(p00) <<< 24;
            dreq.den   <= s_full;
            state      <= S_WD0;
          end
        end
        S_WD0: if (drsp.done) begin
          k0    <= drsp.quo;
          state <= S_DIV1;
        end
        S_DIV1: begin
          dreq.num   <= 64'(p10) <<< 24;
          dreq.den   <= s_full;
          state      <= S_WD1;
        end
        S_WD1: if (drsp.done) begin
          k1    <= drsp.quo;
          state <= S_M_KY0;
        end
        S_M_KY0: begin
          ang   <= sat32(68'(ang) + sh24);
          state <= S_M_KY1;
        end
        S_M_KY1: begin
          bias  <= sat32(68'(bias) + sh24);
          state <= S_M_K0P00;
        end
        S_M_K0P00: begin
          p00   <= sat32(68'(p00) - sh24);
          state <= S_M_K0P01;
        end
        S_M_K0P01: begin
          p01   <= sat32(68'(p01) - sh24);
          state <= S_M_K1P00;
        end
        S_M_K1P00: begin
          p10   <= sat32(68'(p10) - sh24);
          state <= S_M_K1P01;
        end
        S_M_K1P01: begin
          p11   <= sat32(68'(p11) - sh24);
          state <= S_DONE;
        end
        S_DONE: if (!out_valid || !out_stall) begin
          out_valid      <= 1'b1;
          filtered_angle <= ang;
          if (bias > BiasLimit)       bias_estimate <= BiasLimit[27:0];
          else if (bias < -BiasLimit) bias_estimate <= 28'(-BiasLimit);
          else                        bias_estimate <= bias[27:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register never overwritten while held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_angle))
    else $error("result overwritten while stalled");

  // no request taken while busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("request accepted while busy");

  // divider start only asserted in the wait states that follow its launch states
  a_div: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> (state == S_WD0 || state == S_WD1))
    else $error("divider start out of sequence");

endmodule

/* sv/kabf_div.sv */
// Restoring signed divider, truncating quotient saturated to 32 bits, one bit a cycle.
module kabf_div (
  input  logic                   clk,
  input  logic                   rst,
  input  kabf_pkg::kabf_div_req_t req,
  output kabf_pkg::kabf_div_rsp_t rsp
);
  import kabf_pkg::*;

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dmag;
  logic [63:0] nmag;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic signed [67:0] qs;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem[62:0], nmag[63]};
    trial  = {1'b0, rem_sh} - {1'b0, dmag};
  end

  always_comb begin
    qs = neg ? -$signed({4'd0, quo}) : $signed({4'd0, quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses with the last quotient bit
      done <= busy && !req.start && (cnt == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= '0;
        neg  <= req.num[63] ^ req.den[63];
        nmag <= req.num[63] ? 64'(-req.num) : 64'(req.num);
        dmag <= req.den[63] ? 64'(-req.den) : 64'(req.den);
      end else if (busy) begin
        nmag <= {nmag[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = {done, sat32(qs)};

endmodule
